// File: rtl/core/amg_pkg.sv
// amg_pkg: shared types and constants for the adjacency matrix graph store
// command and result item structs, command codes, decoded ops, engine states
// no dependencies
`timescale 1ns / 1ps

package amg_pkg;

    localparam int NODE_W  = 6;
    localparam int NCNT_W  = 7;
    localparam int ECNT_W  = 12;
    localparam int CAP_W   = 7;

    localparam logic [2:0] CMD_ADD_NODE = 3'd0;
    localparam logic [2:0] CMD_REM_NODE = 3'd1;
    localparam logic [2:0] CMD_ADD_EDGE = 3'd2;
    localparam logic [2:0] CMD_REM_EDGE = 3'd3;
    localparam logic [2:0] CMD_GET_EDGE = 3'd4;
    localparam logic [2:0] CMD_LIST_ADJ = 3'd5;
    localparam logic [2:0] CMD_COUNTS   = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN  = 3'd7;

    localparam logic signed [31:0] EDGE_ABSENT = -32'sd1;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd16;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic signed [31:0] weight;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] edge_value;
        logic               reverse_found;
        logic [NODE_W-1:0]  neighbor;
        logic               neighbor_valid;
        logic               last;
        logic [NCNT_W-1:0]  node_count;
        logic [ECNT_W-1:0]  edge_count;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_ADD_NODE,
        OP_REM_NODE,
        OP_ADD_EDGE,
        OP_REM_EDGE,
        OP_GET_EDGE,
        OP_LIST_ADJ,
        OP_COUNTS,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDT,
        ST_EXEC,
        ST_COLRD,
        ST_COLWR,
        ST_REMEND,
        ST_LIST
    } state_t;

endpackage

// File: rtl/core/amg_front.sv
// amg_front: command intake queue, decodes each command into an op
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  amg_pkg::in_item_t cmd_item,
    output logic             work_valid,
    input  logic             work_pop,
    output amg_pkg::work_t   work
);

    amg_pkg::work_t ent_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    amg_pkg::op_t   op_dec;
    logic           do_push, do_pop;

    always_comb
    begin
        unique case (cmd_item.cmd)
            amg_pkg::CMD_ADD_NODE: op_dec = amg_pkg::OP_ADD_NODE;
            amg_pkg::CMD_REM_NODE: op_dec = amg_pkg::OP_REM_NODE;
            amg_pkg::CMD_ADD_EDGE: op_dec = amg_pkg::OP_ADD_EDGE;
            amg_pkg::CMD_REM_EDGE: op_dec = amg_pkg::OP_REM_EDGE;
            amg_pkg::CMD_GET_EDGE: op_dec = amg_pkg::OP_GET_EDGE;
            amg_pkg::CMD_LIST_ADJ: op_dec = amg_pkg::OP_LIST_ADJ;
            amg_pkg::CMD_COUNTS:   op_dec = amg_pkg::OP_COUNTS;
            default:               op_dec = amg_pkg::OP_BAD;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign work_valid = (cnt_reg != 2'd0);
    assign work       = ent_reg[rp_reg];
    assign do_push    = push && !full;
    assign do_pop     = work_pop && work_valid;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg].op   <= op_dec;
            ent_reg[wp_reg].item <= cmd_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/amg_resq.sv
// amg_resq: two-entry result queue between the engine and the result port
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_resq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    output logic               res_full,
    input  amg_pkg::out_item_t res_in,
    output logic               empty,
    input  logic               pop,
    output amg_pkg::out_item_t res_item
);

    amg_pkg::out_item_t ent_reg [2];
    logic               wp_reg, wp_next;
    logic               rp_reg, rp_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign res_item = ent_reg[rp_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/amg_engine.sv
// amg_engine: executes decoded commands against the node map and edge tables
// row valid memory, weight memory, counters and the command state machine
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_engine #(
    parameter int MAX_NODES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [amg_pkg::CAP_W-1:0] cfg_data,
    input  logic               work_valid,
    output logic               work_pop,
    input  amg_pkg::work_t     work,
    output logic               res_push,
    input  logic               res_full,
    output amg_pkg::out_item_t res_out
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int WAW = $clog2(MAX_NODES * MAX_NODES);

    typedef logic [MAX_NODES-1:0] row_t;

    amg_pkg::state_t state_reg, state_next;
    amg_pkg::work_t  cur_reg, cur_next;
    row_t            rowb_reg, rowb_next;
    row_t            scan_reg, scan_next;
    row_t            present_reg, present_next;
    row_t            rowok_reg, rowok_next;
    logic [NW-1:0]   col_reg, col_next;
    logic [amg_pkg::NCNT_W-1:0] nodes_reg, nodes_next;
    logic [amg_pkg::ECNT_W-1:0] edges_reg, edges_next;
    logic [amg_pkg::CAP_W-1:0]  cap_reg;

    // edge valid rows and weights
    row_t               vmem_mem [MAX_NODES];
    logic signed [31:0] wmem_mem [MAX_NODES * MAX_NODES];
    row_t               vrd_reg;
    logic               vok_reg;
    logic signed [31:0] wrd_reg;

    logic               v_we;
    logic [NW-1:0]      v_waddr, v_raddr;
    row_t               v_wdata;
    logic               w_we;
    logic [WAW-1:0]     w_addr;

    logic [amg_pkg::CAP_W-1:0] cap_eff;
    logic [NW-1:0]      b_idx, t_idx;
    row_t               row_eff, bbit, tbit, cbit;
    logic               hn_b, hn_t, diff, has_e, rev, list_last;

    assign cap_eff = (cap_reg > amg_pkg::CAP_W'(MAX_NODES)) ?
                     amg_pkg::CAP_W'(MAX_NODES) : cap_reg;
    assign b_idx   = cur_reg.item.src_node[NW-1:0];
    assign t_idx   = cur_reg.item.dst_node[NW-1:0];
    assign row_eff = vok_reg ? vrd_reg : '0;
    assign bbit    = row_t'(1) << b_idx;
    assign tbit    = row_t'(1) << t_idx;
    assign cbit    = row_t'(1) << col_reg;
    assign hn_b    = (amg_pkg::CAP_W'(cur_reg.item.src_node) < cap_eff)
                     && present_reg[b_idx];
    assign hn_t    = (amg_pkg::CAP_W'(cur_reg.item.dst_node) < cap_eff)
                     && present_reg[t_idx];
    assign diff    = cur_reg.item.src_node != cur_reg.item.dst_node;
    assign has_e   = hn_b && hn_t && diff && rowb_reg[t_idx];
    assign rev     = hn_b && hn_t && diff && row_eff[b_idx];
    assign list_last = ((scan_reg & ~cbit) == '0);
    assign w_addr  = WAW'(b_idx) * WAW'(MAX_NODES) + WAW'(t_idx);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amg_pkg::ST_IDLE:
            begin
                if (work_valid)
                begin
                    state_next = amg_pkg::ST_RDT;
                end
            end
            amg_pkg::ST_RDT:
            begin
                state_next = amg_pkg::ST_EXEC;
            end
            amg_pkg::ST_EXEC:
            begin
                if (cur_reg.op == amg_pkg::OP_REM_NODE && hn_b)
                begin
                    state_next = amg_pkg::ST_COLRD;
                end
                else if (cur_reg.op == amg_pkg::OP_LIST_ADJ && hn_b && rowb_reg != '0)
                begin
                    state_next = amg_pkg::ST_LIST;
                end
                else if (!res_full)
                begin
                    state_next = amg_pkg::ST_IDLE;
                end
            end
            amg_pkg::ST_COLRD:
            begin
                state_next = amg_pkg::ST_COLWR;
            end
            amg_pkg::ST_COLWR:
            begin
                state_next = (col_reg == NW'(MAX_NODES - 1)) ?
                             amg_pkg::ST_REMEND : amg_pkg::ST_COLRD;
            end
            amg_pkg::ST_REMEND:
            begin
                if (!res_full)
                begin
                    state_next = amg_pkg::ST_IDLE;
                end
            end
            amg_pkg::ST_LIST:
            begin
                if (scan_reg[col_reg] && !res_full && list_last)
                begin
                    state_next = amg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amg_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        work_pop     = 1'b0;
        res_push     = 1'b0;
        res_out      = '0;
        res_out.last = 1'b1;
        v_we         = 1'b0;
        v_waddr      = b_idx;
        v_wdata      = '0;
        v_raddr      = t_idx;
        w_we         = 1'b0;
        cur_next     = cur_reg;
        rowb_next    = rowb_reg;
        scan_next    = scan_reg;
        present_next = present_reg;
        rowok_next   = rowok_reg;
        col_next     = col_reg;
        nodes_next   = nodes_reg;
        edges_next   = edges_reg;
        unique case (state_reg)
            amg_pkg::ST_IDLE:
            begin
                v_raddr = work.item.src_node[NW-1:0];
                if (work_valid)
                begin
                    work_pop = 1'b1;
                    cur_next = work;
                end
            end
            amg_pkg::ST_RDT:
            begin
                rowb_next = row_eff;
            end
            amg_pkg::ST_EXEC:
            begin
                case (cur_reg.op)
                    amg_pkg::OP_ADD_NODE:
                    begin
                        if (!res_full)
                        begin
                            res_push = 1'b1;
                            if ((amg_pkg::CAP_W'(cur_reg.item.src_node) < cap_eff)
                                && !present_reg[b_idx])
                            begin
                                res_out.ok   = 1'b1;
                                present_next = present_reg | bbit;
                                nodes_next   = nodes_reg + amg_pkg::NCNT_W'(1);
                            end
                        end
                    end
                    amg_pkg::OP_REM_NODE:
                    begin
                        if (hn_b)
                        begin
                            col_next = '0;
                        end
                        else if (!res_full)
                        begin
                            res_push = 1'b1;
                        end
                    end
                    amg_pkg::OP_ADD_EDGE:
                    begin
                        if (!res_full)
                        begin
                            res_push = 1'b1;
                            if (hn_b && hn_t && diff)
                            begin
                                res_out.ok = 1'b1;
                                v_we       = 1'b1;
                                v_wdata    = rowb_reg | tbit;
                                w_we       = 1'b1;
                                rowok_next = rowok_reg | bbit;
                                if (!rowb_reg[t_idx])
                                begin
                                    edges_next = edges_reg + amg_pkg::ECNT_W'(1);
                                end
                            end
                        end
                    end
                    amg_pkg::OP_REM_EDGE:
                    begin
                        if (!res_full)
                        begin
                            res_push = 1'b1;
                            if (has_e)
                            begin
                                res_out.ok = 1'b1;
                                v_we       = 1'b1;
                                v_wdata    = rowb_reg & ~tbit;
                                edges_next = edges_reg - amg_pkg::ECNT_W'(1);
                            end
                        end
                    end
                    amg_pkg::OP_GET_EDGE:
                    begin
                        if (!res_full)
                        begin
                            res_push              = 1'b1;
                            res_out.ok            = has_e;
                            res_out.edge_value    = has_e ? wrd_reg : amg_pkg::EDGE_ABSENT;
                            res_out.reverse_found = rev;
                        end
                    end
                    amg_pkg::OP_LIST_ADJ:
                    begin
                        if (hn_b && rowb_reg != '0)
                        begin
                            scan_next = rowb_reg;
                            col_next  = '0;
                        end
                        else if (!res_full)
                        begin
                            res_push   = 1'b1;
                            res_out.ok = hn_b;
                        end
                    end
                    amg_pkg::OP_COUNTS:
                    begin
                        if (!res_full)
                        begin
                            res_push           = 1'b1;
                            res_out.ok         = 1'b1;
                            res_out.node_count = nodes_reg;
                            res_out.edge_count = edges_reg;
                        end
                    end
                    default:
                    begin
                        if (!res_full)
                        begin
                            res_push = 1'b1;
                        end
                    end
                endcase
            end
            amg_pkg::ST_COLRD:
            begin
                v_raddr = col_reg;
            end
            amg_pkg::ST_COLWR:
            begin
                // drop column entry of the removed node, count its row entry too
                v_waddr = col_reg;
                v_wdata = row_eff & ~bbit;
                v_we    = row_eff[b_idx];
                edges_next = edges_reg - amg_pkg::ECNT_W'(row_eff[b_idx])
                             - amg_pkg::ECNT_W'(rowb_reg[col_reg]);
                col_next = col_reg + NW'(1);
            end
            amg_pkg::ST_REMEND:
            begin
                if (!res_full)
                begin
                    res_push     = 1'b1;
                    res_out.ok   = 1'b1;
                    present_next = present_reg & ~bbit;
                    rowok_next   = rowok_reg & ~bbit;
                    nodes_next   = nodes_reg - amg_pkg::NCNT_W'(1);
                end
            end
            amg_pkg::ST_LIST:
            begin
                if (!scan_reg[col_reg])
                begin
                    col_next = col_reg + NW'(1);
                end
                else if (!res_full)
                begin
                    res_push               = 1'b1;
                    res_out.ok             = 1'b1;
                    res_out.neighbor       = amg_pkg::NODE_W'(col_reg);
                    res_out.neighbor_valid = 1'b1;
                    res_out.last           = list_last;
                    scan_next              = scan_reg & ~cbit;
                    col_next               = col_reg + NW'(1);
                end
            end
            default:
            begin
                work_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem_mem[v_waddr] <= v_wdata;
        end
        if (w_we)
        begin
            wmem_mem[w_addr] <= cur_reg.item.weight;
        end
        vrd_reg <= vmem_mem[v_raddr];
        vok_reg <= rowok_reg[v_raddr];
        wrd_reg <= wmem_mem[w_addr];
        cur_reg  <= cur_next;
        rowb_reg <= rowb_next;
        scan_reg <= scan_next;
        col_reg  <= col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= amg_pkg::ST_IDLE;
            present_reg <= '0;
            rowok_reg   <= '0;
            nodes_reg   <= '0;
            edges_reg   <= '0;
            cap_reg     <= amg_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            // new capacity starts an empty graph
            state_reg   <= state_next;
            present_reg <= '0;
            rowok_reg   <= '0;
            nodes_reg   <= '0;
            edges_reg   <= '0;
            cap_reg     <= cfg_data;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            rowok_reg   <= rowok_next;
            nodes_reg   <= nodes_next;
            edges_reg   <= edges_next;
        end
    end

endmodule

// File: rtl/core/adjacency_matrix_graph_store_top.sv
// adjacency matrix graph store: command intake queue, command engine and result queue in series
// single-result commands step through row b read, row t read and execute; execute waits while the result queue is full
// node removal walks every row of the row memory, reading then writing the removed node's column entry
// adjacency listing checks one node index per cycle, holding on a neighbor while the result queue is full
// async active-low reset empties both queues and the graph, capacity returns to 16
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_top #(
    parameter int MAX_NODES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  amg_pkg::in_item_t  cmd_item,
    output logic               empty,
    input  logic               pop,
    output amg_pkg::out_item_t res_item,
    input  logic               cfg_we,
    input  logic [amg_pkg::CAP_W-1:0] cfg_data
);

    logic               work_valid, work_pop;
    amg_pkg::work_t     work;
    logic               res_push, res_full;
    amg_pkg::out_item_t res_out;

    amg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_item   (cmd_item),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .work       (work)
    );

    amg_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .work       (work),
        .res_push   (res_push),
        .res_full   (res_full),
        .res_out    (res_out)
    );

    amg_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res_in   (res_out),
        .empty    (empty),
        .pop      (pop),
        .res_item (res_item)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        work_pop |-> work_valid)
        else $error("engine took a command from an empty queue");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        work_pop |=> !work_pop)
        else $error("engine took two commands back to back");
`endif

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for the adjacency matrix graph store
// drives commands from a queue, predicts results with its own graph model
// depends on amg_pkg and adjacency_matrix_graph_store_top
`timescale 1ns / 1ps

module tb_top;

    localparam int MAXN = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    amg_pkg::in_item_t cmd_item;
    logic empty;
    logic pop;
    amg_pkg::out_item_t res_item;
    logic cfg_we;
    logic [amg_pkg::CAP_W-1:0] cfg_data;

    adjacency_matrix_graph_store_top #(.MAX_NODES(MAXN)) u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_item(cmd_item),
        .empty(empty), .pop(pop), .res_item(res_item), .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    // graph shadow
    bit g_node [MAXN];
    bit g_edge [MAXN][MAXN];
    logic [31:0] g_wt [MAXN][MAXN];
    int g_nodes;
    int g_edges;
    int g_cap;

    amg_pkg::in_item_t cmd_pending[$];
    amg_pkg::out_item_t result_expect[$];
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int burst_left;
    int gap_left;
    int stall_phase;
    int stall_len;
    bit stim_done = 1'b0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic void expect_add(amg_pkg::out_item_t r);
        result_expect.insert(result_expect.size(), r);
    endfunction

    function automatic void cmd_add(amg_pkg::in_item_t it);
        cmd_pending.insert(cmd_pending.size(), it);
    endfunction

    function automatic void graph_clear();
        for (int i = 0; i < MAXN; i++)
        begin
            g_node[i] = 0;
            for (int j = 0; j < MAXN; j++)
                g_edge[i][j] = 0;
        end
        g_nodes = 0;
        g_edges = 0;
    endfunction

    function automatic bit node_ok(int n);
        return n < g_cap && g_node[n];
    endfunction

    function automatic bit edge_ok(int b, int t);
        return node_ok(b) && node_ok(t) && b != t && g_edge[b][t];
    endfunction

    function automatic amg_pkg::out_item_t blank_result(bit ok);
        amg_pkg::out_item_t r;
        r = '0;
        r.ok = ok;
        r.last = 1'b1;
        return r;
    endfunction

    // apply one command to the shadow graph, queue the results it yields
    function automatic void graph_apply(amg_pkg::in_item_t it);
        int b;
        int t;
        int lastnb;
        bit ok;
        amg_pkg::out_item_t r;
        b = int'(it.src_node);
        t = int'(it.dst_node);
        ok = 0;
        lastnb = -1;
        case (it.cmd)
            amg_pkg::CMD_ADD_NODE:
            begin
                if (b < g_cap && !g_node[b])
                begin
                    g_node[b] = 1;
                    g_nodes++;
                    ok = 1;
                end
                expect_add(blank_result(ok));
            end
            amg_pkg::CMD_REM_NODE:
            begin
                if (node_ok(b))
                begin
                    for (int i = 0; i < MAXN; i++)
                    begin
                        if (i != b && g_edge[b][i])
                        begin
                            g_edge[b][i] = 0;
                            g_edges--;
                        end
                        if (i != b && g_edge[i][b])
                        begin
                            g_edge[i][b] = 0;
                            g_edges--;
                        end
                    end
                    g_node[b] = 0;
                    g_nodes--;
                    ok = 1;
                end
                expect_add(blank_result(ok));
            end
            amg_pkg::CMD_ADD_EDGE:
            begin
                if (node_ok(b) && node_ok(t) && b != t)
                begin
                    if (!g_edge[b][t])
                    begin
                        g_edge[b][t] = 1;
                        g_edges++;
                    end
                    g_wt[b][t] = it.weight;
                    ok = 1;
                end
                expect_add(blank_result(ok));
            end
            amg_pkg::CMD_REM_EDGE:
            begin
                if (edge_ok(b, t))
                begin
                    g_edge[b][t] = 0;
                    g_edges--;
                    ok = 1;
                end
                expect_add(blank_result(ok));
            end
            amg_pkg::CMD_GET_EDGE:
            begin
                ok = edge_ok(b, t);
                r = blank_result(ok);
                r.edge_value = ok ? g_wt[b][t] : amg_pkg::EDGE_ABSENT;
                r.reverse_found = edge_ok(t, b);
                expect_add(r);
            end
            amg_pkg::CMD_LIST_ADJ:
            begin
                if (node_ok(b))
                    for (int i = 0; i < g_cap; i++)
                        if (i != b && g_edge[b][i])
                            lastnb = i;
                if (lastnb >= 0)
                begin
                    for (int i = 0; i < g_cap; i++)
                        if (i != b && g_edge[b][i])
                        begin
                            r = '0;
                            r.ok = 1;
                            r.neighbor = 6'(i);
                            r.neighbor_valid = 1;
                            r.last = (i == lastnb);
                            expect_add(r);
                        end
                end
                else
                    expect_add(blank_result(node_ok(b)));
            end
            amg_pkg::CMD_COUNTS:
            begin
                r = blank_result(1);
                r.node_count = 7'(g_nodes);
                r.edge_count = 12'(g_edges);
                expect_add(r);
            end
            default:
                expect_add(blank_result(0));
        endcase
    endfunction

    function automatic amg_pkg::in_item_t make_cmd(logic [2:0] c, int b, int t,
                                                   logic [31:0] w);
        amg_pkg::in_item_t it;
        it.cmd = c;
        it.src_node = 6'(b);
        it.dst_node = 6'(t);
        it.weight = w;
        return it;
    endfunction

    // random command biased toward valid nodes so edges build up
    function automatic amg_pkg::in_item_t random_cmd();
        int r;
        int b;
        int t;
        logic [2:0] c;
        r = $urandom_range(0, 99);
        if (r < 20) c = amg_pkg::CMD_ADD_NODE;
        else if (r < 25) c = amg_pkg::CMD_REM_NODE;
        else if (r < 50) c = amg_pkg::CMD_ADD_EDGE;
        else if (r < 58) c = amg_pkg::CMD_REM_EDGE;
        else if (r < 75) c = amg_pkg::CMD_GET_EDGE;
        else if (r < 88) c = amg_pkg::CMD_LIST_ADJ;
        else if (r < 96) c = amg_pkg::CMD_COUNTS;
        else c = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8 && g_cap > 0)
        begin
            b = $urandom_range(0, g_cap - 1);
            t = $urandom_range(0, g_cap - 1);
        end
        else
        begin
            b = $urandom_range(0, 63);
            t = $urandom_range(0, 63);
        end
        return make_cmd(c, b, t, $urandom());
    endfunction

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            cmd_item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (push && !full)
                void'(cmd_pending.pop_front());
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    push <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    push <= 1'b1;
                    cmd_item <= cmd_pending[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted commands, check on accepted results
    always @(posedge clk)
    begin
        amg_pkg::out_item_t exp_r;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (push && !full)
                graph_apply(cmd_item);
            if (pop && !empty)
            begin
                results_seen <= results_seen + 1;
                if (result_expect.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %h", res_item);
                end
                else
                begin
                    exp_r = result_expect.pop_front();
                    if (res_item !== exp_r)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch exp: ok=%b val=%h rev=%b nb=%0d nbv=%b last=%b",
                                exp_r.ok, exp_r.edge_value, exp_r.reverse_found,
                                exp_r.neighbor, exp_r.neighbor_valid, exp_r.last,
                                " nc=%0d ec=%0d", exp_r.node_count, exp_r.edge_count);
                            $display("         got: ok=%b val=%h rev=%b nb=%0d nbv=%b last=%b",
                                res_item.ok, res_item.edge_value, res_item.reverse_found,
                                res_item.neighbor, res_item.neighbor_valid, res_item.last,
                                " nc=%0d ec=%0d", res_item.node_count, res_item.edge_count);
                        end
                    end
                end
            end
        end
    end

    // receiver stall pattern: alternating ready and stall stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_phase <= 0;
            stall_len <= 4;
        end
        else if (stall_phase >= stall_len)
        begin
            stall_phase <= 0;
            stall_len <= $urandom_range(1, 20);
            pop <= ($urandom_range(0, 2) != 0);
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (!pop && $urandom_range(0, 3) == 0)
                pop <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || push || result_expect.size() != 0)
            @(posedge clk);
        repeat (2 * MAXN + 20) @(posedge clk);
    endtask

    task automatic set_capacity(int cap);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 7'(cap);
        @(posedge clk);
        cfg_we <= 1'b0;
        g_cap = (cap > MAXN) ? MAXN : cap;
        graph_clear();
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            // keep the queue short so node picks track the current capacity
            while (cmd_pending.size() > 8)
                @(posedge clk);
            cmd_add(random_cmd());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        g_cap = int'(amg_pkg::CAP_RESET);
        graph_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special cases at reset capacity
        cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, 15, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, 16, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, 63, 63, 32'hffffffff));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_EDGE, 0, 15, 32'h7fffffff));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_EDGE, 15, 0, 32'h80000000));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_EDGE, 0, 0, 32'h1));
        cmd_add(make_cmd(amg_pkg::CMD_GET_EDGE, 0, 15, 0));
        cmd_add(make_cmd(amg_pkg::CMD_GET_EDGE, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_ADD_EDGE, 0, 15, 32'hffffffff));
        cmd_add(make_cmd(amg_pkg::CMD_GET_EDGE, 0, 15, 0));
        cmd_add(make_cmd(amg_pkg::CMD_LIST_ADJ, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_LIST_ADJ, 5, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_COUNTS, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_REM_EDGE, 0, 15, 0));
        cmd_add(make_cmd(amg_pkg::CMD_REM_EDGE, 0, 15, 0));
        cmd_add(make_cmd(amg_pkg::CMD_REM_NODE, 15, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_LIST_ADJ, 0, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_REM_NODE, 15, 0, 0));
        cmd_add(make_cmd(amg_pkg::CMD_UNKNOWN, 63, 63, 32'hffffffff));
        cmd_add(make_cmd(amg_pkg::CMD_COUNTS, 0, 0, 0));
        run_random(80);

        set_capacity(64);
        run_random(60);
        set_capacity(1);
        run_random(30);
        set_capacity(0);
        run_random(20);
        set_capacity(2);
        run_random(30);
        set_capacity(7);
        run_random(90);
        set_capacity(16);
        // add every node and fill row 3 with edges, then random commands list and remove to exercise long runs
        for (int i = 0; i < 16; i++)
            cmd_add(make_cmd(amg_pkg::CMD_ADD_NODE, i, 0, 0));
        wait_drained();
        for (int i = 0; i < 30; i++)
            cmd_add(make_cmd(amg_pkg::CMD_ADD_EDGE, 3, i % 16, $urandom()));
        run_random(100);
        wait_drained();
        stim_done = 1;
    end

    initial
    begin
        @(posedge rst_n);
        while (!stim_done && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (!stim_done)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            $display("ran graph commands across capacities 0,1,2,7,16,64; %0d results checked",
                results_seen);
            $display("mismatches counted: %0d", mismatches);
            if (mismatches == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/amg_pkg.sv
rtl/core/amg_front.sv
rtl/core/amg_resq.sv
rtl/core/amg_engine.sv
rtl/core/adjacency_matrix_graph_store_top.sv
tb/tb_top.sv
